@@ sv/cbps_pkg.sv @@
// Shared types and constants for the cubic Bezier path sampler.
`timescale 1ns / 1ps
package cbps_pkg;

    // Q16.16 coordinate, and a point as x, y, z (index 0 is x)
    typedef logic signed [31:0] coord_t;
    typedef coord_t [2:0] point_t;

    localparam int N_W     = 6;            // samples-per-curve register
    localparam int T_W     = 17;           // t and u in 0..65536
    localparam int B_W     = 18;           // Bernstein weights, up to 3 * 65536
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 19;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 54;

    localparam logic [T_W-1:0] ONE_Q16 = 17'h1_0000;

    // handshake status of a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

@@ sv/cbps_in_if.sv @@
// Request channel carrying one control point.
`timescale 1ns / 1ps
interface cbps_in_if;
    logic               valid;
    logic               ready;
    logic               start_path;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, start_path, point_x, point_y, point_z, input ready);
    modport sink   (input valid, start_path, point_x, point_y, point_z, output ready);
endinterface

@@ sv/cbps_out_if.sv @@
// Request channel carrying one sampled curve point.
`timescale 1ns / 1ps
interface cbps_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] curve_x;
    logic signed [31:0] curve_y;
    logic signed [31:0] curve_z;
    logic               last_of_run;

    modport source (output valid, curve_x, curve_y, curve_z, last_of_run, input ready);
    modport sink   (input valid, curve_x, curve_y, curve_z, last_of_run, output ready);
endinterface

@@ sv/cbps_div.sv @@
// Restoring divider: 65536 / N and 65536 % N, one quotient bit per cycle.
`timescale 1ns / 1ps
module cbps_div
    import cbps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [N_W-1:0]   divisor,
    output unit_stat_t       stat,
    output logic [T_W-1:0]   quot,
    output logic [N_W-1:0]   rmd
);

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    logic [T_W-1:0]   dvd_reg;
    logic [T_W-1:0]   quot_reg;
    logic [N_W-1:0]   rmd_reg;

    logic [N_W:0]     shift_val;
    logic [N_W:0]     diff_val;
    logic             ge;

    // trial subtract of the shifted partial remainder
    assign shift_val = {rmd_reg, dvd_reg[T_W-1]};
    assign ge        = shift_val >= {1'b0, divisor};
    assign diff_val  = shift_val - {1'b0, divisor};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(T_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= ONE_Q16;
            quot_reg <= '0;
            rmd_reg  <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[T_W-2:0], 1'b0};
            quot_reg <= {quot_reg[T_W-2:0], ge};
            rmd_reg  <= ge ? diff_val[N_W-1:0] : shift_val[N_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;
    assign rmd       = rmd_reg;

endmodule

@@ sv/cbps_eval.sv @@
// Curve point evaluator: one shared multiplier stepped through weights and axes.
`timescale 1ns / 1ps
module cbps_eval
    import cbps_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [T_W-1:0] t,
    input  point_t         pts [4],
    output unit_stat_t     stat,
    output point_t         result
);

    // multiplier schedule; a product is registered and written back in the next step
    localparam logic [4:0] STEP_TT       = 5'd0;   // t * t
    localparam logic [4:0] STEP_UU       = 5'd1;   // u * u
    localparam logic [4:0] STEP_B3       = 5'd2;   // tt * t
    localparam logic [4:0] STEP_B0       = 5'd3;   // uu * u
    localparam logic [4:0] STEP_B1       = 5'd4;   // uu * t, then x3
    localparam logic [4:0] STEP_B2       = 5'd5;   // u * tt, then x3
    localparam logic [4:0] STEP_PT_FIRST = 5'd6;   // p[k] * b[k], 4 per axis
    localparam logic [4:0] STEP_PT_LAST  = 5'd17;
    localparam logic [4:0] STEP_LAST     = 5'd18;  // final write back only

    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

    logic                       run_reg;
    logic                       done_reg;
    logic [4:0]                 step_reg;
    logic [T_W-1:0]             tt_reg;
    logic [T_W-1:0]             uu_reg;
    logic [B_W-1:0]             b_reg [4];
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    point_t                     res_reg;

    logic [T_W-1:0]             u;
    logic [4:0]                 pt_off;
    logic [1:0]                 p_k;
    logic [1:0]                 p_ax;
    coord_t                     coord_sel;
    logic signed [MUL_A_W-1:0]  op_a;
    logic signed [MUL_B_W-1:0]  op_b;
    logic signed [PROD_W-1:0]   prod_c;

    logic [4:0]                 wb_idx;
    logic [4:0]                 wb_off;
    logic [1:0]                 wk;
    logic [1:0]                 wax;
    logic [T_W-1:0]             basis;
    logic [B_W-1:0]             basis3;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    sum_c;
    logic signed [ACC_W-1:0]    shifted;
    coord_t                     sat_val;

    assign u = ONE_Q16 - t;

    // operand select for the shared multiplier
    assign pt_off    = step_reg - STEP_PT_FIRST;
    assign p_k       = pt_off[1:0];
    assign p_ax      = pt_off[3:2];
    assign coord_sel = $signed(pts[p_k][p_ax]);

    always_comb
    begin
        case (step_reg)
            STEP_TT:
            begin
                op_a = {16'd0, t};
                op_b = {2'd0, t};
            end
            STEP_UU:
            begin
                op_a = {16'd0, u};
                op_b = {2'd0, u};
            end
            STEP_B3:
            begin
                op_a = {16'd0, tt_reg};
                op_b = {2'd0, t};
            end
            STEP_B0:
            begin
                op_a = {16'd0, uu_reg};
                op_b = {2'd0, u};
            end
            STEP_B1:
            begin
                op_a = {16'd0, uu_reg};
                op_b = {2'd0, t};
            end
            STEP_B2:
            begin
                op_a = {16'd0, u};
                op_b = {2'd0, tt_reg};
            end
            default:
            begin
                op_a = {coord_sel[31], coord_sel};
                op_b = {1'b0, b_reg[p_k]};
            end
        endcase
    end

    assign prod_c = op_a * op_b;

    // write back of the previous step's product
    assign wb_idx   = step_reg - 5'd1;
    assign wb_off   = wb_idx - STEP_PT_FIRST;
    assign wk       = wb_off[1:0];
    assign wax      = wb_off[3:2];
    assign basis    = prod_reg[32:16];
    assign basis3   = {1'b0, basis} + {basis, 1'b0};
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign sum_c    = acc_reg + prod_ext;
    assign shifted  = sum_c >>> 16;

    // floor shift done above; clamp to the signed 32-bit range
    always_comb
    begin
        if (shifted > SAT_HI)
            sat_val = SAT_HI[31:0];
        else if (shifted < SAT_LO)
            sat_val = SAT_LO[31:0];
        else
            sat_val = shifted[31:0];
    end

    // step sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == STEP_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // product register, weights, accumulator and result
    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            prod_reg <= prod_c;
            if (step_reg != STEP_TT)
            begin
                case (wb_idx)
                    STEP_TT: tt_reg   <= basis;
                    STEP_UU: uu_reg   <= basis;
                    STEP_B3: b_reg[3] <= {1'b0, basis};
                    STEP_B0: b_reg[0] <= {1'b0, basis};
                    STEP_B1: b_reg[1] <= basis3;
                    STEP_B2: b_reg[2] <= basis3;
                    default:
                    begin
                        if (wb_idx inside {[STEP_PT_FIRST:STEP_PT_LAST]})
                        begin
                            if (wk == 2'd0)
                                acc_reg <= prod_ext;
                            else
                                acc_reg <= sum_c;
                            if (wk == 2'd3)
                                res_reg[wax] <= sat_val;
                        end
                    end
                endcase
            end
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule

@@ sv/cubic_bezier_path_sampler_core.sv @@
// Top level of the cubic Bezier path sampler: point intake, sequencing, output register.
//
// Usage:
//   point_ch takes control points (valid/ready). The first point of a path, or any
//   point with start_path set, is the start point. Each further group of three
//   points completes a cubic curve; the completing point makes the block emit
//   segments_per_curve samples at t = j/N (plus the start point on the first curve
//   of a path) on sample_ch, with last_of_run on the final one.
//   cfg_wr_en/cfg_wr_data write N (samples per curve); write only while idle.
// Sequence:
//   A point that completes no curve is taken at once while idle. A completing point
//   first waits on the divider for 65536 / N (17 quotient bits plus hand-off) unless N
//   is 0; each sample then takes 18 multiplies through the one shared
//   multiplier plus setup and hand-off. point_ch.ready is low for the whole run.
// Reset puts N at 16 and forgets any path. If sample_ch stalls, the finished
//   sample stays in the output register and the sequencer waits before loading
//   the next one; ready returns as soon as the last sample is loaded.
`timescale 1ns / 1ps
module cubic_bezier_path_sampler_core
    import cbps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [N_W-1:0]    cfg_wr_data,
    cbps_in_if.sink           point_ch,
    cbps_out_if.source        sample_ch
);

    localparam logic [1:0] PH_NONE = 2'd0;   // start point only
    localparam logic [1:0] PH_ONE  = 2'd1;   // p1 held

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_NEXT,
        ST_CALC,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [N_W-1:0]     n_reg;
    point_t             pts_reg [4];
    logic [1:0]         phase_reg;
    logic               started_reg;
    logic               first_done_reg;
    logic               zero_pend_reg;
    logic [N_W:0]       rem_reg;
    logic [T_W-1:0]     t_reg;
    logic [N_W-1:0]     frac_reg;
    logic               ov_reg;
    point_t             out_pt_reg;
    logic               olast_reg;

    logic               in_fire;
    logic               out_fire;
    logic               emit_load;
    logic               curve_go;
    logic [N_W:0]       rem_init;
    point_t             in_pt;
    logic [N_W:0]       frac_sum;
    logic [N_W:0]       frac_diff;
    logic               frac_carry;
    logic [T_W:0]       t_sum;
    logic [T_W-1:0]     t_next;
    logic [N_W-1:0]     frac_next;

    unit_stat_t         div_stat;
    logic [T_W-1:0]     div_quot;
    logic [N_W-1:0]     div_rmd;
    unit_stat_t         eval_stat;
    point_t             eval_res;

    // handshakes
    assign point_ch.ready = (state_reg == ST_IDLE);
    assign in_fire        = point_ch.valid && point_ch.ready;
    assign out_fire       = sample_ch.valid && sample_ch.ready;
    assign emit_load      = (state_reg == ST_EMIT) && (!ov_reg || sample_ch.ready);

    assign in_pt[0] = point_ch.point_x;
    assign in_pt[1] = point_ch.point_y;
    assign in_pt[2] = point_ch.point_z;

    // samples owed by a completing point
    assign rem_init = {1'b0, n_reg} + {{N_W{1'b0}}, !first_done_reg};
    assign curve_go = in_fire && !point_ch.start_path && started_reg
                      && (phase_reg != PH_NONE) && (phase_reg != PH_ONE);

    // t advance: t += 65536 div N, carrying the remainder
    assign frac_sum   = {1'b0, frac_reg} + {1'b0, div_rmd};
    assign frac_carry = frac_sum >= {1'b0, n_reg};
    assign frac_diff  = frac_sum - {1'b0, n_reg};
    assign frac_next  = frac_carry ? frac_diff[N_W-1:0] : frac_sum[N_W-1:0];
    assign t_sum      = {1'b0, t_reg} + {1'b0, div_quot} + {{T_W{1'b0}}, frac_carry};
    assign t_next     = t_sum[T_W-1:0];

    cbps_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (curve_go && (rem_init != '0) && (n_reg != '0)),
        .divisor (n_reg),
        .stat    (div_stat),
        .quot    (div_quot),
        .rmd     (div_rmd)
    );

    cbps_eval u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == ST_NEXT),
        .t      (t_reg),
        .pts    (pts_reg),
        .stat   (eval_stat),
        .result (eval_res)
    );

    // sequencer, held points and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            n_reg          <= N_W'(16);
            phase_reg      <= PH_NONE;
            started_reg    <= 1'b0;
            first_done_reg <= 1'b0;
            zero_pend_reg  <= 1'b0;
            rem_reg        <= '0;
            t_reg          <= '0;
            frac_reg       <= '0;
            ov_reg         <= 1'b0;
            olast_reg      <= 1'b0;
            out_pt_reg     <= '0;
            for (int i = 0; i < 4; i++)
                pts_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                n_reg <= cfg_wr_data;
            if (out_fire && !emit_load)
                ov_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (point_ch.start_path || !started_reg)
                        begin
                            pts_reg[0]     <= in_pt;
                            phase_reg      <= PH_NONE;
                            started_reg    <= 1'b1;
                            first_done_reg <= 1'b0;
                        end
                        else if (phase_reg == PH_NONE)
                        begin
                            pts_reg[1] <= in_pt;
                            phase_reg  <= PH_ONE;
                        end
                        else if (phase_reg == PH_ONE)
                        begin
                            pts_reg[2] <= in_pt;
                            phase_reg  <= 2'd2;
                        end
                        else
                        begin
                            pts_reg[3]    <= in_pt;
                            rem_reg       <= rem_init;
                            zero_pend_reg <= !first_done_reg;
                            t_reg         <= '0;
                            frac_reg      <= '0;
                            if (rem_init == '0)
                            begin
                                // curve with no samples: just move on
                                pts_reg[0]     <= in_pt;
                                phase_reg      <= PH_NONE;
                                first_done_reg <= 1'b1;
                            end
                            else if (n_reg == '0)
                                state_reg <= ST_NEXT;
                            else
                                state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                        state_reg <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    // start point first on a new path, then advancing t
                    if (zero_pend_reg)
                        zero_pend_reg <= 1'b0;
                    else
                    begin
                        t_reg    <= t_next;
                        frac_reg <= frac_next;
                    end
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    if (eval_stat.done)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        ov_reg     <= 1'b1;
                        out_pt_reg <= eval_res;
                        olast_reg  <= (rem_reg == 7'd1);
                        rem_reg    <= rem_reg - 7'd1;
                        if (rem_reg == 7'd1)
                        begin
                            pts_reg[0]     <= pts_reg[3];
                            phase_reg      <= PH_NONE;
                            first_done_reg <= 1'b1;
                            state_reg      <= ST_IDLE;
                        end
                        else
                            state_reg <= ST_NEXT;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign sample_ch.valid       = ov_reg;
    assign sample_ch.curve_x     = out_pt_reg[0];
    assign sample_ch.curve_y     = out_pt_reg[1];
    assign sample_ch.curve_z     = out_pt_reg[2];
    assign sample_ch.last_of_run = olast_reg;

    // evaluator runs only while the sequencer waits on it
    a_eval_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (eval_stat.busy || eval_stat.done) |-> (state_reg == ST_CALC))
        else $error("evaluator active outside CALC");

    // divider runs only while the sequencer waits on it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> (state_reg == ST_DIV))
        else $error("divider active outside DIV");

    // a run in progress always owes at least one sample
    a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (rem_reg != '0))
        else $error("run in progress with no samples owed");

    // t never passes 1.0
    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        t_reg <= ONE_Q16)
        else $error("t out of range");

    // the final sample of a run carries the last flag and frees the input
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && (rem_reg == 7'd1)) |=>
        ((state_reg == ST_IDLE) && sample_ch.valid && sample_ch.last_of_run))
        else $error("last sample not flagged");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the cubic Bezier path sampler core.
`timescale 1ns / 1ps
module tb_top
    import cbps_pkg::*;
();

    localparam int     TIMEOUT_CYCLES = 3_000_000;
    localparam int     DRAIN_CYCLES   = 120;
    localparam int     SQUEEZE_LEN    = 400;
    localparam int     MAX_REPORTS    = 10;
    localparam coord_t MAXC           = 32'sh7fff_ffff;
    localparam coord_t MINC           = 32'sh8000_0000;

    typedef struct packed {
        logic   start_path;
        coord_t x;
        coord_t y;
        coord_t z;
    } ctrl_point_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } curve_sample_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_wr_en;
    logic [N_W-1:0] cfg_wr_data;

    cbps_in_if  point_if ();
    cbps_out_if sample_if ();

    cubic_bezier_path_sampler_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .point_ch    (point_if),
        .sample_ch   (sample_if)
    );

    // stimulus and expectations
    ctrl_point_t   point_pend_q[$];
    curve_sample_t sample_exp_q[$];

    // path tracking mirror
    logic [N_W-1:0] seg_count;
    coord_t         held[3][3];
    int             curve_phase;
    logic           path_open;
    logic           first_curve_emitted;

    int   send_idle_pct;
    int   recv_idle_pct;
    int   mismatch_count;
    int   cycle_count = 0;
    int   hold_left;
    logic squeeze_go;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one axis of the Bernstein sum, floored to Q16.16 and saturated
    function automatic coord_t bezier_coord(input longint p0, input longint p1,
                                            input longint p2, input longint p3,
                                            input longint b0, input longint b1,
                                            input longint b2, input longint b3);
        longint acc;
        longint r;
        acc = p0 * b0 + p1 * b1 + p2 * b2 + p3 * b3;
        r   = acc >>> 16;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return coord_t'(r[31:0]);
    endfunction

    // update path state for one accepted point and queue the samples it causes
    function automatic void advance_path(input logic sp, input coord_t x,
                                         input coord_t y, input coord_t z);
        longint        pts[4][3];
        longint        t, u, tt, uu, b0, b1, b2, b3;
        int            n;
        curve_sample_t s;
        if (sp || !path_open)
        begin
            held[0][0] = x;
            held[0][1] = y;
            held[0][2] = z;
            curve_phase = 0;
            path_open = 1'b1;
            first_curve_emitted = 1'b0;
            return;
        end
        if (curve_phase < 2)
        begin
            held[curve_phase + 1][0] = x;
            held[curve_phase + 1][1] = y;
            held[curve_phase + 1][2] = z;
            curve_phase++;
            return;
        end
        for (int k = 0; k < 3; k++)
            for (int a = 0; a < 3; a++)
                pts[k][a] = longint'(held[k][a]);
        pts[3][0] = longint'(x);
        pts[3][1] = longint'(y);
        pts[3][2] = longint'(z);
        n = int'(seg_count);
        // t = 0 only on the first curve of a path
        for (int j = first_curve_emitted ? 1 : 0; j <= n; j++)
        begin
            t  = (j == 0) ? 0 : (longint'(j) * 65536) / n;
            u  = 65536 - t;
            tt = (t * t) >> 16;
            uu = (u * u) >> 16;
            b0 = (uu * u) >> 16;
            b1 = ((uu * t) >> 16) * 3;
            b2 = ((u * tt) >> 16) * 3;
            b3 = (tt * t) >> 16;
            s.x = bezier_coord(pts[0][0], pts[1][0], pts[2][0], pts[3][0], b0, b1, b2, b3);
            s.y = bezier_coord(pts[0][1], pts[1][1], pts[2][1], pts[3][1], b0, b1, b2, b3);
            s.z = bezier_coord(pts[0][2], pts[1][2], pts[2][2], pts[3][2], b0, b1, b2, b3);
            s.last = (j == n);
            sample_exp_q.push_back(s);
        end
        held[0][0] = x;
        held[0][1] = y;
        held[0][2] = z;
        curve_phase = 0;
        first_curve_emitted = 1'b1;
    endfunction

    // mix of full-range, near-zero and extreme coordinates
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0, 1:    return coord_t'($urandom);
            2:       return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return MAXC;
                    1:       return MINC;
                    2:       return 32'sh0;
                    default: return -32'sh1;
                endcase
            end
        endcase
    endfunction

    task automatic queue_point(input logic sp, input coord_t x, input coord_t y,
                               input coord_t z);
        ctrl_point_t p;
        p.start_path = sp;
        p.x = x;
        p.y = y;
        p.z = z;
        point_pend_q.push_back(p);
    endtask

    // mostly well-formed paths, with an occasional restart anywhere
    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            queue_point($urandom_range(0, 15) == 0, rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic write_segments(input logic [N_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        seg_count = value;
    endtask

    // all points taken, all samples seen, then let the block settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (point_pend_q.size() != 0 || point_if.valid || sample_exp_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // point driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_if.valid      <= 1'b0;
            point_if.start_path <= 1'b0;
            point_if.point_x    <= '0;
            point_if.point_y    <= '0;
            point_if.point_z    <= '0;
        end
        else
        begin : drive_points
            ctrl_point_t nxt;
            if (point_if.valid && point_if.ready)
                advance_path(point_if.start_path, point_if.point_x, point_if.point_y,
                             point_if.point_z);
            if (!point_if.valid || point_if.ready)
            begin
                if (point_pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = point_pend_q.pop_front();
                    point_if.valid      <= 1'b1;
                    point_if.start_path <= nxt.start_path;
                    point_if.point_x    <= nxt.x;
                    point_if.point_y    <= nxt.y;
                    point_if.point_z    <= nxt.z;
                end
                else
                begin
                    point_if.valid <= 1'b0;
                end
            end
        end
    end

    // sample monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_if.ready <= 1'b0;
        end
        else
        begin : check_samples
            curve_sample_t want;
            if (sample_if.valid && sample_if.ready)
            begin
                if (sample_exp_q.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected sample x=%h y=%h z=%h last=%b",
                                 sample_if.curve_x, sample_if.curve_y,
                                 sample_if.curve_z, sample_if.last_of_run);
                    mismatch_count++;
                end
                else
                begin
                    want = sample_exp_q.pop_front();
                    if (sample_if.curve_x !== want.x || sample_if.curve_y !== want.y ||
                        sample_if.curve_z !== want.z || sample_if.last_of_run !== want.last)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("mismatch: exp %h %h %h %b, got %h %h %h %b",
                                     want.x, want.y, want.z, want.last,
                                     sample_if.curve_x, sample_if.curve_y,
                                     sample_if.curve_z, sample_if.last_of_run);
                        mismatch_count++;
                    end
                end
            end
            sample_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (squeeze_go)
            hold_left <= SQUEEZE_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        squeeze_go          = 1'b0;
        point_if.valid      = 1'b0;
        point_if.start_path = 1'b0;
        point_if.point_x    = '0;
        point_if.point_y    = '0;
        point_if.point_z    = '0;
        sample_if.ready     = 1'b0;
        seg_count           = 6'd16;
        curve_phase         = 0;
        path_open           = 1'b0;
        first_curve_emitted = 1'b0;
        mismatch_count      = 0;
        for (int k = 0; k < 3; k++)
            for (int a = 0; a < 3; a++)
                held[k][a] = '0;
        send_idle_pct = 17;
        recv_idle_pct = 88;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset segment count
        queue_point(1'b0, 32'sh0, 32'sh0, 32'sh0);          // no path yet: becomes start
        queue_point(1'b0, MAXC, MINC, 32'sh0);
        queue_point(1'b0, MINC, MAXC, -32'sh1);
        queue_point(1'b0, 32'sh0001_0000, -32'sh0001_0000, 32'sh1234_5678);
        queue_point(1'b0, MAXC, MAXC, MAXC);                // continuation curve, saturating
        queue_point(1'b0, MAXC, MAXC, MAXC);
        queue_point(1'b0, MAXC, MAXC, MAXC);
        queue_point(1'b0, MINC, MINC, MINC);
        queue_point(1'b0, MINC, MINC, MINC);
        queue_point(1'b0, MINC, MINC, MINC);
        queue_point(1'b1, 32'sh0005_0000, 32'sh0003_8000, -32'sh0002_0000);
        queue_point(1'b0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        queue_point(1'b1, -32'sh1, -32'sh1, -32'sh1);       // restart drops held control point
        queue_point(1'b0, 32'sh0010_0000, -32'sh0010_0000, 32'sh0000_8000);
        queue_point(1'b0, -32'sh0020_0000, 32'sh0020_0000, 32'sh0000_0001);
        queue_point(1'b0, 32'sh0030_0000, 32'sh0000_0000, -32'sh0000_0001);
        queue_point(1'b0, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f);
        queue_point(1'b0, 32'shf0f0_f0f0, 32'sh3333_3333, 32'shcccc_cccc);
        queue_point(1'b1, 32'sh7fff_0000, 32'sh8000_ffff, 32'sh0000_ffff); // restart with two held
        queue_point(1'b0, 32'sh0000_0001, MINC, MAXC);
        queue_point(1'b0, MAXC, 32'sh0000_0001, MINC);
        queue_point(1'b0, MINC, MAXC, 32'sh0000_0001);
        queue_point(1'b0, -32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
        queue_point(1'b0, 32'sh0004_0000, -32'sh0005_0000, 32'sh0006_0000);
        queue_point(1'b0, -32'sh0007_0000, 32'sh0008_0000, -32'sh0009_0000);
        wait_idle();

        // largest segment count
        write_segments(6'd63);
        queue_random(30);
        wait_idle();

        // single segment, sender mostly idle
        send_idle_pct = 88;
        recv_idle_pct = 17;
        write_segments(6'd1);
        queue_random(40);
        wait_idle();

        // zero segments: only the start sample of a first curve
        write_segments(6'd0);
        queue_random(30);
        wait_idle();

        // no idling, with a long receiver stall up front
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_segments(6'($urandom_range(2, 12)));
        queue_random(40);
        @(posedge clk);
        squeeze_go <= 1'b1;
        @(posedge clk);
        squeeze_go <= 1'b0;
        wait_idle();

        write_segments(6'($urandom_range(2, 20)));
        queue_random(15);
        wait_idle();

        if (sample_exp_q.size() != 0)
        begin
            $display("%0d expected samples never arrived", sample_exp_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ cubic_bezier_path_sampler_core.f @@
sv/cbps_pkg.sv
sv/cbps_in_if.sv
sv/cbps_out_if.sv
sv/cbps_div.sv
sv/cbps_eval.sv
sv/cubic_bezier_path_sampler_core.sv
verif/tb_top.sv
